>>> design/crra_pkg.sv
// Shared widths, register codes and channel payload types of the capacity round-robin assigner.
package crra_pkg;

   localparam int MaxUnitsDefault = 64;

   localparam int NodeW     = 16;
   localparam int UnitIdxW  = 6;
   localparam int UnitsCfgW = 7;
   localparam int CapW      = 17;
   localparam int CsrIdxW   = 1;

   localparam logic [UnitsCfgW-1:0] UnitsReset = UnitsCfgW'(64);
   localparam logic [CapW-1:0]      CapReset   = CapW'(1024);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_UNITS_IN_USE  = 1'b0,
      CSR_UNIT_CAPACITY = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [NodeW-1:0] node_id;
      logic             layer_start;
   } req_type;

   typedef struct packed {
      logic [NodeW-1:0]    placed_node;
      logic [UnitIdxW-1:0] unit_index;
      logic                all_full;
   } rsp_type;

   typedef struct packed {
      csr_idx_type     index;
      logic [CapW-1:0] data;
   } csr_type;

endpackage

>>> design/crra_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
interface crra_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/crra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crra_ram #(
   parameter int WIDTH = crra_pkg::CapW,
   parameter int DEPTH = crra_pkg::MaxUnitsDefault,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> design/capacity_round_robin_assigner_unit.sv
// Top level: places nodes on units round-robin under a per-unit fill limit.
//
//   channel    dir   payload                                 handshake
//   req_chan   in    node_id, layer_start                    valid/ready
//   rsp_chan   out   placed_node, unit_index, all_full       valid/ready
//   csr_chan   in    index (units_in_use, unit_capacity),    valid/ready (ready tied high)
//                    data
//
// A result is registered when the scan finds a unit below the fill limit, full units
// skipped; if all n effective units are full, all_full is reported instead.
// The scan reads one fill count per cycle from the fill RAM and tests it in one comparator.
// After reset a clearing pass zeroes every fill RAM entry; req_chan is not
// ready meanwhile. One request is handled at a time: req_chan is ready again once the
// previous result has been transferred.
module capacity_round_robin_assigner_unit #(
   parameter int MAX_UNITS = crra_pkg::MaxUnitsDefault
) (
   input  logic          clock,
   input  logic          reset,
   crra_stream_if.sink   req_chan,
   crra_stream_if.source rsp_chan,
   crra_stream_if.sink   csr_chan
);
   import crra_pkg::*;

   localparam int PtrW      = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int CmpW      = (PtrW > UnitsCfgW) ? PtrW : UnitsCfgW;
   localparam int UnitLimit = (MAX_UNITS < 127) ? MAX_UNITS : 127;
   localparam logic [UnitsCfgW-1:0] UnitsMax = UnitsCfgW'(UnitLimit);
   localparam logic [PtrW-1:0]      LastAddr = PtrW'(MAX_UNITS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [UnitsCfgW-1:0]  units_ff;
   logic [CapW-1:0]       cap_ff;
   logic [PtrW-1:0]       clr_ff, clr_in;
   logic [PtrW-1:0]       next_ff, next_in;
   logic [PtrW-1:0]       probe_ff, probe_in;
   logic [PtrW-1:0]       look_ff, look_in;
   logic                  look_vld_ff, look_vld_in;
   logic [UnitsCfgW-1:0]  checked_ff, checked_in;
   logic [NodeW-1:0]      node_ff, node_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [UnitIdxW-1:0]   rsp_unit_ff, rsp_unit_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic [UnitsCfgW-1:0]  n_eff;
   logic [UnitsCfgW-1:0]  n_last;
   logic [PtrW-1:0]       start_raw;
   logic [PtrW-1:0]       start_pos;
   logic [PtrW-1:0]       probe_wrap;
   logic [PtrW-1:0]       look_wrap;
   logic                  req_xfer;
   logic                  csr_xfer;

   logic                  ram_we;
   logic [PtrW-1:0]       ram_waddr;
   logic [CapW-1:0]       ram_wdata;
   logic [CapW-1:0]       ram_rdata;

   crra_ram #(
      .WIDTH (CapW),
      .DEPTH (MAX_UNITS)
   ) u_fill_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (probe_ff),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_xfer       = csr_chan.valid && csr_chan.ready;

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.payload.placed_node = node_ff;
   assign rsp_chan.payload.unit_index  = rsp_unit_ff;
   assign rsp_chan.payload.all_full    = rsp_full_ff;

   // Zero units counts as one; more than the RAM holds is clamped.
   always_comb begin
      if (units_ff == '0) begin
         n_eff = UnitsCfgW'(1);
      end else if (units_ff > UnitsMax) begin
         n_eff = UnitsMax;
      end else begin
         n_eff = units_ff;
      end
      n_last = n_eff - UnitsCfgW'(1);
   end

   always_comb begin
      start_raw  = req_chan.payload.layer_start ? '0 : next_ff;
      start_pos  = (CmpW'(start_raw) >= CmpW'(n_eff)) ? '0 : start_raw;
      probe_wrap = (CmpW'(probe_ff) == CmpW'(n_last)) ? '0 : probe_ff + PtrW'(1);
      look_wrap  = (CmpW'(look_ff) == CmpW'(n_last)) ? '0 : look_ff + PtrW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_in      = next_ff;
      probe_in     = probe_ff;
      look_in      = look_ff;
      look_vld_in  = look_vld_ff;
      checked_in   = checked_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_unit_in  = rsp_unit_ff;
      rsp_full_in  = rsp_full_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + PtrW'(1);
            if (clr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               node_in     = req_chan.payload.node_id;
               probe_in    = start_pos;
               look_vld_in = 1'b0;
               checked_in  = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Read one unit ahead while testing the count that just arrived.
            probe_in    = probe_wrap;
            look_in     = probe_ff;
            look_vld_in = 1'b1;
            if (look_vld_ff) begin
               if (ram_rdata < cap_ff) begin
                  ram_we       = 1'b1;
                  ram_waddr    = look_ff;
                  ram_wdata    = ram_rdata + CapW'(1);
                  next_in      = look_wrap;
                  rsp_valid_in = 1'b1;
                  rsp_unit_in  = UnitIdxW'(look_ff);
                  rsp_full_in  = 1'b0;
                  state_in     = ST_IDLE;
               end else if (checked_ff == n_last) begin
                  // Every unit full: report and leave the pointer alone.
                  rsp_valid_in = 1'b1;
                  rsp_unit_in  = '0;
                  rsp_full_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  checked_in = checked_ff + UnitsCfgW'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_ff      <= '0;
         look_vld_ff  <= 1'b0;
         checked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_ff      <= next_in;
         look_vld_ff  <= look_vld_in;
         checked_ff   <= checked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff    <= probe_in;
      look_ff     <= look_in;
      node_ff     <= node_in;
      rsp_unit_ff <= rsp_unit_in;
      rsp_full_ff <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff <= UnitsReset;
         cap_ff   <= CapReset;
      end else if (csr_xfer) begin
         case (csr_chan.payload.index)
            CSR_UNITS_IN_USE:  units_ff <= csr_chan.payload.data[UnitsCfgW-1:0];
            CSR_UNIT_CAPACITY: cap_ff   <= csr_chan.payload.data;
            default: ;
         endcase
      end
   end

   a_ram_write_owner : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_SCAN))
      else $error("fill RAM written outside clear pass or scan");

   a_rsp_from_scan : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SCAN)
      else $error("result raised without a scan");

   a_scan_write_valid : assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff == ST_SCAN)) |-> look_vld_ff && !rsp_valid_ff)
      else $error("fill count updated from a stale read");

   a_full_on_fail : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_unit_ff == '0))
      else $error("failed placement carries a unit index");

endmodule

>>> verif/capacity_round_robin_assigner_unit_tb.sv
// Self-checking testbench for the capacity round-robin assigner: directed table, random walks.
module capacity_round_robin_assigner_unit_tb;
   import crra_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UnitCount  = MaxUnitsDefault;
   localparam int CycleLimit = 1_000_000;
   localparam int HoldCycles = 400;
   localparam int DrainWait  = UnitCount + 16;

   typedef struct packed {
      logic             is_csr;
      csr_idx_type      idx;
      logic [CapW-1:0]  data;
      logic [NodeW-1:0] node;
      logic             layer;
      logic             typed;
      logic [UnitIdxW-1:0] exp_unit;
      logic             exp_full;
   } plan_row_type;

   // Fixed rows: register writes and nodes; typed expectations only where obvious.
   localparam int NumRows = 24;
   localparam plan_row_type DirectedPlan [NumRows] = '{
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h0000, 1'b1, 1'b1, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'hFFFF, 1'b0, 1'b1, 6'd1, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h1234, 1'b1, 1'b1, 6'd0, 1'b0},
      '{1'b1, CSR_UNIT_CAPACITY, 17'd0,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'hAAAA, 1'b0, 1'b1, 6'd0, 1'b1},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h5555, 1'b1, 1'b1, 6'd0, 1'b1},
      '{1'b1, CSR_UNIT_CAPACITY, 17'd1,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h0F0F, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b1, CSR_UNITS_IN_USE,  17'd1,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'hF0F0, 1'b0, 1'b1, 6'd0, 1'b1},
      '{1'b1, CSR_UNITS_IN_USE,  17'd0,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h00FF, 1'b0, 1'b1, 6'd0, 1'b1},
      '{1'b1, CSR_UNIT_CAPACITY, 17'd3,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'hFF00, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h8000, 1'b1, 1'b1, 6'd0, 1'b1},
      '{1'b1, CSR_UNITS_IN_USE,  17'd127,    16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h7FFF, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b1, CSR_UNITS_IN_USE,  17'd65,     16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h0001, 1'b1, 1'b0, 6'd0, 1'b0},
      '{1'b1, CSR_UNIT_CAPACITY, 17'h1FFFF,  16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b1, CSR_UNITS_IN_USE,  17'd2,      16'h0000, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h4321, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h1357, 1'b0, 1'b0, 6'd0, 1'b0},
      '{1'b0, CSR_UNITS_IN_USE,  17'd0,      16'h2468, 1'b0, 1'b0, 6'd0, 1'b0}
   };

   localparam int NumPhases = 8;
   localparam int PhaseUnits [NumPhases] = '{4, 64, 7, 1, 0, 127, 33, 64};
   localparam int PhaseCap   [NumPhases] = '{8, 4, 80, 200, 0, 65536, 50, 131071};
   localparam int PhaseLen   [NumPhases] = '{60, 300, 250, 150, 40, 300, 300, 300};
   localparam int TunedPhases = 3;
   localparam int TunedLen    = 45;

   logic clock;
   logic reset;

   crra_stream_if #(.payload_type(req_type)) req_if ();
   crra_stream_if #(.payload_type(rsp_type)) rsp_if ();
   crra_stream_if #(.payload_type(csr_type)) csr_if ();

   capacity_round_robin_assigner_unit #(
      .MAX_UNITS(UnitCount)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Shadow of the block's state and registers
   logic [CapW-1:0]      fill_count [UnitCount];
   logic [UnitIdxW-1:0]  search_ptr;
   logic [UnitsCfgW-1:0] units_cfg;
   logic [CapW-1:0]      capacity_cfg;

   rsp_type pending_placements [$];
   int      mismatches;
   int      placed_total;
   int      refused_total;
   int      writes_total;
   int      cycle_count;
   bit      steady;
   bit      hold_req;
   int      hold_left;
   logic [NodeW-1:0] node_cursor;

   always #10 clock = ~clock;

   function automatic int active_units();
      if (units_cfg == 0) return 1;
      if (units_cfg > UnitCount) return UnitCount;
      return int'(units_cfg);
   endfunction

   function automatic void place_node(input req_type r, output rsp_type res);
      int  n;
      int  pos;
      int  k;
      bit  found;
      n = active_units();
      pos = r.layer_start ? 0 : int'(search_ptr);
      found = 1'b0;
      if (pos >= n) pos = 0;
      for (k = 0; k < n; k++) begin
         if (fill_count[pos] < capacity_cfg) begin
            found = 1'b1;
            break;
         end
         pos = (pos + 1) % n;
      end
      res.placed_node = r.node_id;
      if (found) begin
         fill_count[pos] = fill_count[pos] + 1'b1;
         search_ptr = UnitIdxW'((pos + 1) % n);
         res.unit_index = UnitIdxW'(pos);
         res.all_full = 1'b0;
         placed_total++;
      end else begin
         res.unit_index = '0;
         res.all_full = 1'b1;
         refused_total++;
      end
   endfunction

   task automatic offer_node(input logic [NodeW-1:0] node, input logic layer, input bit typed,
                             input logic [UnitIdxW-1:0] t_unit, input logic t_full);
      rsp_type want;
      req_type item;
      if (!steady && $urandom_range(0, 99) < 12) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      item.node_id = node;
      item.layer_start = layer;
      req_if.payload = item;
      req_if.valid = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      place_node(item, want);
      if (typed) begin
         want.unit_index = t_unit;
         want.all_full = t_full;
      end
      pending_placements = {pending_placements, want};
      @(negedge clock);
   endtask

   // Stop offering and wait until every placement has come back.
   task automatic settle();
      req_if.valid = 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CapW-1:0] data);
      csr_type w;
      w.index = idx;
      w.data = data;
      csr_if.payload = w;
      csr_if.valid = 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_UNITS_IN_USE) units_cfg = data[UnitsCfgW-1:0];
      else capacity_cfg = data;
      writes_total++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Layers open with a start flag; a few items get a random flag as noise.
   task automatic walk_layers(input int count);
      int sent;
      int len;
      int i;
      logic layer;
      logic [NodeW-1:0] id;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 16);
         for (i = 0; i < len && sent < count; i++) begin
            layer = (i == 0);
            if ($urandom_range(0, 99) < 8) layer = 1'($urandom_range(0, 1));
            id = ($urandom_range(0, 99) < 80) ? node_cursor : NodeW'($urandom_range(0, 65535));
            node_cursor++;
            offer_node(id, layer, 1'b0, '0, 1'b0);
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HoldCycles;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = steady || ($urandom_range(0, 99) >= 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_placements.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got %p", $time, rsp_if.payload);
            mismatches++;
         end else begin
            if (rsp_if.payload.placed_node !== pending_placements[0].placed_node) begin
               $display("%0t: placed_node expected %h, got %h", $time,
                        pending_placements[0].placed_node, rsp_if.payload.placed_node);
               mismatches++;
            end
            if (rsp_if.payload.unit_index !== pending_placements[0].unit_index) begin
               $display("%0t: unit_index expected %0d, got %0d", $time,
                        pending_placements[0].unit_index, rsp_if.payload.unit_index);
               mismatches++;
            end
            if (rsp_if.payload.all_full !== pending_placements[0].all_full) begin
               $display("%0t: all_full expected %b, got %b", $time,
                        pending_placements[0].all_full, rsp_if.payload.all_full);
               mismatches++;
            end
            void'(pending_placements.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d placements outstanding", $time,
                  pending_placements.size());
         $display("[capacity_round_robin_assigner_unit] ERROR");
         $finish;
      end
   end

   initial begin
      int r;
      int p;
      int k;
      int n_eff;
      logic [CapW-1:0] lowest;
      plan_row_type row;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready = 1'b0;
      mismatches = 0;
      placed_total = 0;
      refused_total = 0;
      writes_total = 0;
      cycle_count = 0;
      steady = 1'b0;
      hold_req = 1'b0;
      hold_left = 0;
      node_cursor = '0;
      for (k = 0; k < UnitCount; k++) fill_count[k] = '0;
      search_ptr = '0;
      units_cfg = UnitsReset;
      capacity_cfg = CapReset;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < NumRows; r++) begin
         row = DirectedPlan[r];
         if (row.is_csr) begin
            settle();
            write_reg(row.idx, row.data);
         end else begin
            offer_node(row.node, row.layer, row.typed, row.exp_unit, row.exp_full);
         end
      end

      for (p = 0; p < NumPhases; p++) begin
         settle();
         write_reg(CSR_UNITS_IN_USE, CapW'(PhaseUnits[p]));
         write_reg(CSR_UNIT_CAPACITY, CapW'(PhaseCap[p]));
         // Stall the result side while requests keep coming.
         if (p == 1) hold_req = 1'b1;
         steady = (p == 5);
         walk_layers(PhaseLen[p]);
      end
      steady = 1'b0;

      // Set capacity at or just above the lowest fill so the units run full again.
      for (p = 0; p < TunedPhases; p++) begin
         settle();
         write_reg(CSR_UNITS_IN_USE, CapW'($urandom_range(0, 127)));
         n_eff = active_units();
         lowest = fill_count[0];
         for (k = 1; k < n_eff; k++)
            if (fill_count[k] < lowest) lowest = fill_count[k];
         write_reg(CSR_UNIT_CAPACITY, lowest + CapW'($urandom_range(0, 3)));
         walk_layers(TunedLen);
      end

      settle();
      repeat (DrainWait) @(posedge clock);
      $display("Covered %0d placements and %0d refusals with all units full,", placed_total,
               refused_total);
      $display("across %0d register writes incl. zero, clamped and stale-pointer settings.",
               writes_total);
      if (mismatches == 0) begin
         $display("[capacity_round_robin_assigner_unit] OK");
      end else begin
         $display("[capacity_round_robin_assigner_unit] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/crra_pkg.sv
design/crra_stream_if.sv
design/crra_ram.sv
design/capacity_round_robin_assigner_unit.sv
verif/capacity_round_robin_assigner_unit_tb.sv
